// ----- rtl/ipv4_longest_prefix_match_core_assert.svh -----
// ---------------------------------------------------------------------------
// ipv4 longest prefix match assertion macros
// shared property wrappers for the lpm core, clocked on clk
// ---------------------------------------------------------------------------
`ifndef IPV4_LONGEST_PREFIX_MATCH_CORE_ASSERT_SVH
`define IPV4_LONGEST_PREFIX_MATCH_CORE_ASSERT_SVH

// checked only out of reset
`define LPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ipv4lpm_pkg.sv -----
// ---------------------------------------------------------------------------
// ipv4 longest prefix match package
// table size, codes, the token that walks the cell chain, mask helpers
// ---------------------------------------------------------------------------
package ipv4lpm_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_DEL   = 2'd1,
    ACT_CHECK = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  localparam logic [6:0] NO_MATCH = 7'h7F;

  // request walking down the chain, with what the cells found so far
  typedef struct packed {
    logic             vld;
    action_t          act;
    logic [31:0]      base;
    logic [5:0]       plen;
    logic [31:0]      addr;
    logic             bad;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
    logic             best_found;
    logic [5:0]       best_len;
  } token_t;

  // entry update broadcast from the chain tail
  typedef struct packed {
    logic             en;
    logic             set;
    logic [IDX_W-1:0] idx;
    logic [31:0]      base;
    logic [5:0]       plen;
  } wr_t;

  // length 0 gives an all-zero mask
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    m = ~(32'hFFFF_FFFF >> len);
    return m;
  endfunction

  function automatic logic prefix_ok(input logic [31:0] base, input logic [5:0] len);
    logic ok;
    ok = (len <= 6'd32) && ((base & ~len_mask(len)) == 32'd0);
    return ok;
  endfunction

endpackage

// ----- rtl/ipv4_longest_prefix_match_core.sv -----
// ---------------------------------------------------------------------------
// ipv4 longest prefix match core
// prefix table with add, delete and longest-prefix lookup over a cell chain
// ---------------------------------------------------------------------------
// The table is a row of TABLE_ENTRIES cells, one prefix each. An accepted
// beat becomes a token that moves one cell per clock; every cell checks it
// against its own entry (exact match for add and delete, masked compare for a
// lookup) and records the lowest free slot. When the token leaves the last
// cell the add or delete is applied to the chosen cell, the count updates and
// the result beat is registered. One item is in the chain at a time, so a new
// beat is taken only once the last one has left the chain and the spare
// result slot is free. A finished result waits in the output register (with
// one spare slot behind it) while the next item walks the chain. No clearing
// pass is needed after reset: entry valid bits clear at once. A check always
// answers ok; action code 3 answers invalid and changes nothing.
// ---------------------------------------------------------------------------
module ipv4_longest_prefix_match_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // prefix_base[31:0], prefix_len[37:32],
                                  // query_address[69:38], zero pad [71:70]
  input  logic [1:0]  in_tuser,   // action[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[1:0], match_len[8:2] (signed),
                                  // stored_count[15:9]
);

  `include "ipv4_longest_prefix_match_core_assert.svh"

  localparam int N     = ipv4lpm_pkg::TABLE_ENTRIES;
  localparam int IDX_W = ipv4lpm_pkg::IDX_W;
  localparam int CNT_W = ipv4lpm_pkg::CNT_W;

  // result beat
  typedef struct packed {
    logic [6:0] stored_count;
    logic [6:0] match_len;
    logic [1:0] status;
  } res_t;

  logic                in_acc;
  logic                busy_r;
  ipv4lpm_pkg::token_t head_r;
  ipv4lpm_pkg::token_t tok_q [0:N];
  ipv4lpm_pkg::token_t tail;
  ipv4lpm_pkg::wr_t    wr;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  res_t                res;
  res_t                out_data_r;
  res_t                pend_data_r;
  logic                out_tvalid_r;
  logic                pend_valid_r;

  // one item at a time; hold off while the spare result slot is taken
  assign in_tready = !busy_r && !pend_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  // -------------------------------------------------------------------------
  // chain head: unpack the beat and pre-check the prefix
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
      busy_r     <= 1'b0;
    end else begin
      head_r.vld <= in_acc;
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (tail.vld) begin
        busy_r <= 1'b0;
      end
    end
    // payload loads on accept only, vld qualifies it
    if (in_acc) begin
      head_r.act        <= ipv4lpm_pkg::action_t'(in_tuser[1:0]);
      head_r.base       <= in_tdata[31:0];
      head_r.plen       <= in_tdata[37:32];
      head_r.addr       <= in_tdata[69:38];
      head_r.bad        <= !ipv4lpm_pkg::prefix_ok(in_tdata[31:0], in_tdata[37:32]);
      head_r.hit        <= 1'b0;
      head_r.hit_idx    <= '0;
      head_r.free       <= 1'b0;
      head_r.free_idx   <= '0;
      head_r.best_found <= 1'b0;
      head_r.best_len   <= '0;
    end
  end

  // -------------------------------------------------------------------------
  // cell chain
  // -------------------------------------------------------------------------
  assign tok_q[0] = head_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    ipv4lpm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (IDX_W'(i)),
      .tok_i (tok_q[i]),
      .wr_i  (wr),
      .tok_o (tok_q[i+1])
    );
  end

  assign tail = tok_q[N];

  // -------------------------------------------------------------------------
  // commit at the chain tail: entry update, count and result
  // -------------------------------------------------------------------------
  always_comb begin
    wr            = '0;
    wr.idx        = tail.free_idx;
    wr.base       = tail.base;
    wr.plen       = tail.plen;
    count_nxt     = count_r;
    res.status    = ipv4lpm_pkg::ST_OK;
    res.match_len = ipv4lpm_pkg::NO_MATCH;
    unique case (tail.act)
      ipv4lpm_pkg::ACT_ADD: begin
        if (tail.bad) begin
          res.status = ipv4lpm_pkg::ST_INVALID;
        end else if (!tail.hit) begin
          // duplicates fall through as ok with no change
          if (tail.free) begin
            wr.en     = tail.vld;
            wr.set    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            res.status = ipv4lpm_pkg::ST_FULL;
          end
        end
      end
      ipv4lpm_pkg::ACT_DEL: begin
        if (tail.bad) begin
          res.status = ipv4lpm_pkg::ST_INVALID;
        end else if (tail.hit) begin
          wr.en     = tail.vld;
          wr.set    = 1'b0;
          wr.idx    = tail.hit_idx;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ipv4lpm_pkg::ACT_CHECK: begin
        if (tail.best_found) begin
          res.match_len = {1'b0, tail.best_len};
        end
      end
      default: begin
        res.status = ipv4lpm_pkg::ST_INVALID;
      end
    endcase
    res.stored_count = 7'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (tail.vld) begin
      count_r <= count_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // output register with one spare slot behind it
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (tail.vld) begin
      if (!out_tvalid_r || out_tready) begin
        out_tvalid_r <= 1'b1;
      end else begin
        pend_valid_r <= 1'b1;
      end
    end else if (out_tvalid_r && out_tready) begin
      out_tvalid_r <= pend_valid_r;
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.vld) begin
      if (!out_tvalid_r || out_tready) begin
        out_data_r <= res;
      end else begin
        pend_data_r <= res;
      end
    end else if (out_tvalid_r && out_tready && pend_valid_r) begin
      out_data_r <= pend_data_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  `LPM_ASSERT(a_pend_behind_out, pend_valid_r |-> out_tvalid_r, "spare slot full with empty output")
  `LPM_ASSERT(a_tail_no_pend, tail.vld |-> (busy_r && !pend_valid_r), "token finished with no room")
  `LPM_ASSERT(a_acc_busy, in_acc |=> (busy_r && head_r.vld), "accepted beat did not enter chain")
  `LPM_ASSERT(a_count_bound, count_r <= CNT_W'(N), "stored count above table size")
  `LPM_ASSERT_ALWAYS(a_no_write_idle, wr.en |-> tail.vld, "entry write without finished token")

endmodule

// ----- rtl/ipv4lpm_cell.sv -----
// ---------------------------------------------------------------------------
// ipv4 lpm table cell
// one table entry; checks the passing token and hands it to the next cell
// ---------------------------------------------------------------------------
module ipv4lpm_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ipv4lpm_pkg::IDX_W-1:0] idx,
  input  ipv4lpm_pkg::token_t         tok_i,
  input  ipv4lpm_pkg::wr_t            wr_i,
  output ipv4lpm_pkg::token_t         tok_o
);

  logic                 ent_valid_r;
  logic [31:0]          ent_base_r;
  logic [5:0]           ent_len_r;
  ipv4lpm_pkg::token_t  tok_r;
  ipv4lpm_pkg::token_t  tok_nxt;
  logic                 exact;
  logic                 covers;

  assign exact  = ent_valid_r && (ent_base_r == tok_i.base) && (ent_len_r == tok_i.plen);
  assign covers = ent_valid_r &&
                  ((tok_i.addr & ipv4lpm_pkg::len_mask(ent_len_r)) == ent_base_r) &&
                  (!tok_i.best_found || (ent_len_r > tok_i.best_len));

  always_comb begin
    tok_nxt = tok_i;
    if (exact && !tok_i.hit) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_idx = idx;
    end
    // lowest free slot wins
    if (!ent_valid_r && !tok_i.free) begin
      tok_nxt.free     = 1'b1;
      tok_nxt.free_idx = idx;
    end
    if (covers) begin
      tok_nxt.best_found = 1'b1;
      tok_nxt.best_len   = ent_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
      tok_r.vld   <= 1'b0;
    end else begin
      tok_r.vld <= tok_i.vld;
      if (wr_i.en && (wr_i.idx == idx)) begin
        ent_valid_r <= wr_i.set;
      end
    end
    // payload needs no reset, vld qualifies it
    tok_r.act        <= tok_nxt.act;
    tok_r.base       <= tok_nxt.base;
    tok_r.plen       <= tok_nxt.plen;
    tok_r.addr       <= tok_nxt.addr;
    tok_r.bad        <= tok_nxt.bad;
    tok_r.hit        <= tok_nxt.hit;
    tok_r.hit_idx    <= tok_nxt.hit_idx;
    tok_r.free       <= tok_nxt.free;
    tok_r.free_idx   <= tok_nxt.free_idx;
    tok_r.best_found <= tok_nxt.best_found;
    tok_r.best_len   <= tok_nxt.best_len;
    if (wr_i.en && wr_i.set && (wr_i.idx == idx)) begin
      ent_base_r <= wr_i.base;
      ent_len_r  <= wr_i.plen;
    end
  end

  assign tok_o = tok_r;

endmodule
